>>> design/rate_paced_sample_framer_unit_defines.svh
// Assertion macros for the rate paced sample framer.
// Used by rate_paced_sample_framer_unit for its concurrent checks; expects clk and rst_n in scope.
`ifndef RATE_PACED_SAMPLE_FRAMER_UNIT_DEFINES_SVH
`define RATE_PACED_SAMPLE_FRAMER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication check
`define RPSF_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpsf check failed");
// Next-cycle implication check
`define RPSF_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpsf check failed");
`else
`define RPSF_ASSERT_IMP(name, ante, cons)
`define RPSF_ASSERT_NXT(name, ante, cons)
`endif

`endif

>>> design/rpsf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the rate paced sample framer.
// No dependencies; the store, phase and framer modules refer to it by scoped names.
package rpsf_pkg;

    localparam int ACC_W  = 20;
    localparam int RATE_W = 10;

    localparam logic [ACC_W-1:0] PHASE_STEP     = 20'd1000;
    localparam logic [ACC_W:0]   PHASE_STEP_NEG = {(ACC_W + 1){1'b0}} - {1'b0, PHASE_STEP};
    localparam logic [31:0]      MAX_GAP        = 32'd1000;
    localparam logic [15:0]      DEFAULT_RATE   = 16'd200;
    localparam logic [2:0]       MAX_PER_FRAME  = 3'd4;

    localparam logic [15:0] TARGET_RATE_RST = 16'd200;
    localparam logic [9:0]  SAMPLE_RATE_RST = 10'd100;
    localparam logic [2:0]  SPF_RST         = 3'd2;

    // Item kinds on the sensor channel
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [1:0] {
        REG_TARGET_RATE       = 2'd0,
        REG_SAMPLE_RATE       = 2'd1,
        REG_SAMPLES_PER_FRAME = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] value;
    } cfg_item_t;

    typedef struct packed {
        logic               action;
        logic [47:0]        in_accel;
        logic [47:0]        in_gyro;
        logic [63:0]        in_quat;
        logic signed [31:0] elapsed_ms;
        logic [31:0]        host_time_ms;
    } sensor_item_t;

    typedef struct packed {
        logic [15:0] frame_seq;
        logic [31:0] frame_time_ms;
        logic [9:0]  frame_rate;
        logic [2:0]  frame_len;
        logic [1:0]  sample_index;
        logic [47:0] out_accel;
        logic [47:0] out_gyro;
        logic [63:0] out_quat;
        logic        last_of_frame;
        logic        last_of_run;
    } frame_item_t;

    typedef struct packed {
        logic [47:0] accel;
        logic [47:0] gyro;
        logic [63:0] quat;
    } sample_t;

    // Operations of the shared phase unit
    typedef enum logic [2:0] {
        PH_NONE,
        PH_CLEAR,
        PH_MUL,
        PH_ADD,
        PH_STEP
    } phase_op_t;

    typedef struct packed {
        phase_op_t         op;
        logic [RATE_W-1:0] rate;
        logic [9:0]        gap;
    } phase_cmd_t;

    typedef struct packed {
        logic above_step;
    } phase_stat_t;

endpackage

>>> design/rpsf_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interface with a typed payload.
// Payload types come from rpsf_pkg.
interface rpsf_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/rpsf_store.sv
`timescale 1ns / 1ps
// Sample ring storage: one write port, one registered read port.
// Depends on rpsf_pkg for the sample type.
module rpsf_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  rpsf_pkg::sample_t wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output rpsf_pkg::sample_t rd_data
);

    rpsf_pkg::sample_t mem [DEPTH];
    rpsf_pkg::sample_t rd_data_reg;

    // Write sample, register read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/rpsf_phase.sv
`timescale 1ns / 1ps
// Phase accumulator unit: one multiplier stage and one shared adder that either
// adds rate * gap with saturation or steps down by 1000; it can also clear. Uses rpsf_pkg.
module rpsf_phase (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rpsf_pkg::phase_cmd_t  cmd,
    output rpsf_pkg::phase_stat_t stat
);

    logic [rpsf_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [rpsf_pkg::ACC_W-1:0] prod_reg, prod_next;
    logic [rpsf_pkg::ACC_W-1:0] mul_full;
    logic [rpsf_pkg::ACC_W:0]   addend;
    logic [rpsf_pkg::ACC_W:0]   sum;

    // Multiply rate by gap (both 10 bit, product fits 20 bits)
    assign mul_full  = {10'b0, cmd.rate} * {10'b0, cmd.gap};
    assign prod_next = (cmd.op == rpsf_pkg::PH_MUL) ? mul_full : prod_reg;

    // Shared adder: add product, or subtract one phase step
    assign addend = (cmd.op == rpsf_pkg::PH_STEP) ? rpsf_pkg::PHASE_STEP_NEG
                                                 : {1'b0, prod_reg};
    assign sum    = {1'b0, acc_reg} + addend;

    always_comb
    begin
        acc_next = acc_reg;
        case (cmd.op)
            rpsf_pkg::PH_CLEAR: acc_next = '0;
            rpsf_pkg::PH_ADD:   acc_next = sum[rpsf_pkg::ACC_W] ? '1
                                                                : sum[rpsf_pkg::ACC_W-1:0];
            rpsf_pkg::PH_STEP:  acc_next = sum[rpsf_pkg::ACC_W-1:0];
            default:            acc_next = acc_reg;
        endcase
    end

    // Hold accumulator and product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            prod_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            prod_reg <= prod_next;
        end
    end

    assign stat.above_step = (acc_reg >= rpsf_pkg::PHASE_STEP);

endmodule

>>> design/rate_paced_sample_framer_unit.sv
`timescale 1ns / 1ps
// Rate paced sample framer: channels
//   sensor - push items (action 0) write one sample into the ring; tick items
//            (action 1) advance the phase accumulator and emit frames.
//   frame  - one item per emitted sample, with frame and run end marks.
//   cfg    - register writes (index 0 target rate, 1 sample rate,
//            2 samples per frame), always ready; write only while idle.
// Sequence: a push is taken in the idle state. A tick clamps the rate, then
// multiplies and accumulates (MUL, ADD), then per frame steps and compares in
// the step/compare unit (CHECK) and per sample does a registered memory read
// (READ) and an output load (LOAD), ending with a final compare in CHECK.
// The shared phase adder and the single read port of the ring set this order.
// sensor is not ready while a tick is in progress.
// Reset empties the ring, clears the accumulator and the sequence counter and
// restores register defaults. A stalled frame receiver holds the output
// register; the sequencer waits before loading the next sample.
`include "rate_paced_sample_framer_unit_defines.svh"
module rate_paced_sample_framer_unit #(
    parameter int FIFO_DEPTH = 64
) (
    input logic        clk,
    input logic        rst_n,
    rpsf_chan_if.sink   sensor,
    rpsf_chan_if.source frame,
    rpsf_chan_if.sink   cfg
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = (AW > 3) ? AW : 3;
    localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_CHECK,
        ST_READ,
        ST_LOAD
    } state_t;

    state_t                state_reg;
    logic [AW-1:0]         wp_reg, rp_reg, cnt_reg;
    logic [15:0]           frame_cnt_reg;
    logic [9:0]            rate_reg;
    logic [9:0]            gap_reg;
    logic                  gap_ok_reg;
    logic [31:0]           time_reg;
    logic [2:0]            want_reg, got_reg, idx_reg;
    logic                  out_valid_reg;
    rpsf_pkg::frame_item_t out_data_reg;

    logic [15:0] target_rate_reg;
    logic [9:0]  sample_rate_reg;
    logic [2:0]  spf_reg;

    logic [15:0]           rate_wide;
    logic [9:0]            rate_clamped;
    logic [2:0]            want;
    logic                  gap_ok;
    logic [AW-1:0]         wp_inc, rp_inc;
    logic [CW-1:0]         cnt_ext, want_ext;
    logic [2:0]            got;
    logic [2:0]            idx_inc;
    logic                  last_frame;
    logic                  more_frames;
    logic                  out_free;
    logic                  load_fire;
    logic                  in_fire;
    rpsf_pkg::sensor_item_t item;
    rpsf_pkg::sample_t     wr_sample, rd_sample;
    rpsf_pkg::phase_cmd_t  phase_cmd;
    rpsf_pkg::phase_stat_t phase_stat;

    assign item    = sensor.data;
    assign in_fire = sensor.valid && sensor.ready;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_rate_reg <= rpsf_pkg::TARGET_RATE_RST;
            sample_rate_reg <= rpsf_pkg::SAMPLE_RATE_RST;
            spf_reg         <= rpsf_pkg::SPF_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                rpsf_pkg::REG_TARGET_RATE:       target_rate_reg <= cfg.data.value;
                rpsf_pkg::REG_SAMPLE_RATE:       sample_rate_reg <= cfg.data.value[9:0];
                rpsf_pkg::REG_SAMPLES_PER_FRAME: spf_reg         <= cfg.data.value[2:0];
                default:                         ;
            endcase
        end
    end

    // Clamp the frame rate: zero means default, cap at sample rate, floor at one
    always_comb
    begin
        rate_wide = (target_rate_reg == 16'd0) ? rpsf_pkg::DEFAULT_RATE : target_rate_reg;
        if (rate_wide > {6'b0, sample_rate_reg})
        begin
            rate_wide = {6'b0, sample_rate_reg};
        end
        if (rate_wide == 16'd0)
        begin
            rate_wide = 16'd1;
        end
        rate_clamped = rate_wide[9:0];
    end

    // Clamp samples per frame to one .. MAX_PER_FRAME
    always_comb
    begin
        want = (spf_reg == 3'd0) ? 3'd1 : spf_reg;
        if (want > rpsf_pkg::MAX_PER_FRAME)
        begin
            want = rpsf_pkg::MAX_PER_FRAME;
        end
    end

    // Gap is usable only if positive and at most 1000 ms
    assign gap_ok = !item.elapsed_ms[31] && (item.elapsed_ms != 32'sd0)
                    && (unsigned'(item.elapsed_ms) <= rpsf_pkg::MAX_GAP);

    // Ring pointer advance
    assign wp_inc = (wp_reg == LAST_SLOT) ? '0 : wp_reg + AW'(1);
    assign rp_inc = (rp_reg == LAST_SLOT) ? '0 : rp_reg + AW'(1);

    // Frame size: min(fill, wanted)
    assign cnt_ext  = CW'(cnt_reg);
    assign want_ext = CW'(want_reg);
    assign got      = (cnt_ext < want_ext) ? 3'(cnt_ext) : want_reg;

    assign idx_inc     = idx_reg + 3'd1;
    assign last_frame  = (idx_inc == got_reg);
    assign more_frames = phase_stat.above_step && (cnt_reg != AW'(1));
    assign out_free    = !out_valid_reg || frame.ready;
    assign load_fire   = (state_reg == ST_LOAD) && out_free;

    // Drive the shared phase unit
    always_comb
    begin
        phase_cmd.op   = rpsf_pkg::PH_NONE;
        phase_cmd.rate = rate_reg;
        phase_cmd.gap  = gap_reg;
        case (state_reg)
            ST_MUL:   phase_cmd.op = gap_ok_reg ? rpsf_pkg::PH_MUL : rpsf_pkg::PH_CLEAR;
            ST_ADD:   phase_cmd.op = gap_ok_reg ? rpsf_pkg::PH_ADD : rpsf_pkg::PH_NONE;
            ST_CHECK: phase_cmd.op = phase_stat.above_step ? rpsf_pkg::PH_STEP
                                                           : rpsf_pkg::PH_NONE;
            default:  phase_cmd.op = rpsf_pkg::PH_NONE;
        endcase
    end

    rpsf_phase u_phase (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (phase_cmd),
        .stat  (phase_stat)
    );

    // Sample ring
    assign wr_sample.accel = item.in_accel;
    assign wr_sample.gyro  = item.in_gyro;
    assign wr_sample.quat  = item.in_quat;

    rpsf_store #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (in_fire && (item.action == rpsf_pkg::ACT_PUSH)),
        .wr_addr (wp_reg),
        .wr_data (wr_sample),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (rp_reg),
        .rd_data (rd_sample)
    );

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            cnt_reg       <= '0;
            frame_cnt_reg <= '0;
            rate_reg      <= '0;
            gap_reg       <= '0;
            gap_ok_reg    <= 1'b0;
            time_reg      <= '0;
            want_reg      <= '0;
            got_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // Drop the output item once taken, unless the next one loads now
            if (frame.ready && !load_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (item.action == rpsf_pkg::ACT_PUSH)
                        begin
                            // Full ring (FIFO_DEPTH - 1 samples): drop the oldest sample
                            wp_reg <= wp_inc;
                            if (cnt_reg == LAST_SLOT)
                            begin
                                rp_reg <= rp_inc;
                            end
                            else
                            begin
                                cnt_reg <= cnt_reg + AW'(1);
                            end
                        end
                        else
                        begin
                            rate_reg   <= rate_clamped;
                            gap_reg    <= item.elapsed_ms[9:0];
                            gap_ok_reg <= gap_ok;
                            time_reg   <= item.host_time_ms;
                            want_reg   <= want;
                            state_reg  <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    // Step down one phase if above the step; a phase below the step or an empty ring ends the run
                    if (phase_stat.above_step && (got != 3'd0))
                    begin
                        got_reg   <= got;
                        idx_reg   <= '0;
                        state_reg <= ST_READ;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg              <= 1'b1;
                        out_data_reg.frame_seq     <= frame_cnt_reg;
                        out_data_reg.frame_time_ms <= time_reg;
                        out_data_reg.frame_rate    <= rate_reg;
                        out_data_reg.frame_len     <= got_reg;
                        out_data_reg.sample_index  <= idx_reg[1:0];
                        out_data_reg.out_accel     <= rd_sample.accel;
                        out_data_reg.out_gyro      <= rd_sample.gyro;
                        out_data_reg.out_quat      <= rd_sample.quat;
                        out_data_reg.last_of_frame <= last_frame;
                        out_data_reg.last_of_run   <= last_frame && !more_frames;
                        rp_reg                     <= rp_inc;
                        cnt_reg                    <= cnt_reg - AW'(1);
                        idx_reg                    <= idx_inc;
                        if (last_frame)
                        begin
                            frame_cnt_reg <= frame_cnt_reg + 16'd1;
                            state_reg     <= ST_CHECK;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign sensor.ready = (state_reg == ST_IDLE);
    assign frame.valid  = out_valid_reg;
    assign frame.data   = out_data_reg;

    // Checks
    `RPSF_ASSERT_IMP(a_no_read_empty, state_reg == ST_READ, cnt_reg != '0)
    `RPSF_ASSERT_IMP(a_step_above, phase_cmd.op == rpsf_pkg::PH_STEP, phase_stat.above_step)
    `RPSF_ASSERT_IMP(a_run_end_frame, out_valid_reg && out_data_reg.last_of_run, out_data_reg.last_of_frame)
    `RPSF_ASSERT_IMP(a_index_in_frame, out_valid_reg, 3'(out_data_reg.sample_index) < out_data_reg.frame_len)
    `RPSF_ASSERT_NXT(a_seq_advance, load_fire && last_frame, frame_cnt_reg == $past(frame_cnt_reg) + 16'd1)

endmodule
